[rtl/rdsrt_pkg.sv]
// ----------------------------------------------------------------------------
// rdsrt_pkg - shared types and constants of the RadioText assembler
// Group field positions, result codes, the command passed from the front
// end to the sequencer, and the result item.
// ----------------------------------------------------------------------------
package rdsrt_pkg;

    localparam int TEXT_LENGTH = 64;
    localparam int ROWS        = TEXT_LENGTH / 2;  // store holds character pairs
    localparam int ROW_W       = $clog2(ROWS);
    localparam int POS_W       = $clog2(TEXT_LENGTH);
    localparam int SEGMENTS    = 16;
    localparam int SEG_W       = $clog2(SEGMENTS);

    localparam logic [3:0]          GROUP_TYPE_RT = 4'h2;
    localparam logic [15:0]         SPACE_PAIR    = 16'h2020;
    localparam logic [SEGMENTS-1:0] ALL_SEGMENTS  = {SEGMENTS{1'b1}};

    typedef enum logic [2:0] {
        ST_IGNORED    = 3'd0,
        ST_STORED     = 3'd1,
        ST_FIRST_DONE = 3'd2,
        ST_MISMATCH   = 3'd3,
        ST_TEXT       = 3'd4
    } t_status;

    // Classified group: one or two 16-bit character pairs at consecutive rows.
    typedef struct packed {
        logic             is_text;
        logic [SEG_W-1:0] seg;
        logic             two_rows;
        logic [ROW_W-1:0] row0;
        logic [15:0]      word0;
        logic [15:0]      word1;
    } t_cmd;

    typedef struct packed {
        t_status          status;
        logic [7:0]       text_char;
        logic [POS_W-1:0] char_position;
        logic             last;
    } t_result;

endpackage

[rtl/rdsrt_ram.sv]
// ----------------------------------------------------------------------------
// rdsrt_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module rdsrt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/rdsrt_queue.sv]
// ----------------------------------------------------------------------------
// rdsrt_queue - two-entry queue
// Decouples producer and consumer; full and empty flags from a fill count.
// ----------------------------------------------------------------------------
module rdsrt_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr, n_wptr;
    logic             r_rptr, n_rptr;
    logic [1:0]       r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = do_push ? ~r_wptr : r_wptr;
        n_rptr  = do_pop ? ~r_rptr : r_rptr;
        n_count = r_count + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

[rtl/rdsrt_front.sv]
// ----------------------------------------------------------------------------
// rdsrt_front - group intake and classification
// Decode group type, version and segment into a store command and queue it.
// ----------------------------------------------------------------------------
module rdsrt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [15:0]       i_block_b,
    input  logic [15:0]       i_block_c,
    input  logic [15:0]       i_block_d,
    output logic              o_cmd_valid,
    output rdsrt_pkg::t_cmd   o_cmd,
    input  logic              i_cmd_pop
);

    rdsrt_pkg::t_cmd               cmd;
    logic                          version_b;
    logic [rdsrt_pkg::SEG_W-1:0]   seg;
    logic [$bits(rdsrt_pkg::t_cmd)-1:0] q_data;
    logic                          q_empty;

    assign version_b = i_block_b[11];
    assign seg       = i_block_b[rdsrt_pkg::SEG_W-1:0];

    always_comb begin
        cmd.is_text  = (i_block_b[15:12] == rdsrt_pkg::GROUP_TYPE_RT);
        cmd.seg      = seg;
        // Version A: four characters at pair rows 2*seg and 2*seg+1.
        // Version B: two characters at pair row seg.
        cmd.two_rows = !version_b;
        cmd.row0     = version_b ? {1'b0, seg} : {seg, 1'b0};
        cmd.word0    = version_b ? i_block_d : i_block_c;
        cmd.word1    = i_block_d;
    end

    rdsrt_queue #(
        .WIDTH($bits(rdsrt_pkg::t_cmd))
    ) u_cmd_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_push),
        .i_data (cmd),
        .o_full (o_full),
        .i_pop  (i_cmd_pop),
        .o_data (q_data),
        .o_empty(q_empty)
    );

    assign o_cmd       = rdsrt_pkg::t_cmd'(q_data);
    assign o_cmd_valid = !q_empty;

endmodule

[rtl/rdsrt_back.sv]
// ----------------------------------------------------------------------------
// rdsrt_back - verify, store and stream sequencer
// Compare against the stored text on the second pass, write characters,
// track segments and stream the finished text into the result queue.
// ----------------------------------------------------------------------------
module rdsrt_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  rdsrt_pkg::t_cmd     i_cmd,
    output logic                o_cmd_pop,
    input  logic                i_res_pop,
    output logic                o_res_empty,
    output rdsrt_pkg::t_result  o_res
);

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_RD0  = 12'b0000_0000_0010,
        S_RD1  = 12'b0000_0000_0100,
        S_CHK  = 12'b0000_0000_1000,
        S_DEC  = 12'b0000_0001_0000,
        S_WR0  = 12'b0000_0010_0000,
        S_WR1  = 12'b0000_0100_0000,
        S_UPD  = 12'b0000_1000_0000,
        S_EMIT = 12'b0001_0000_0000,
        S_SRD  = 12'b0010_0000_0000,
        S_SHI  = 12'b0100_0000_0000,
        S_SLO  = 12'b1000_0000_0000
    } t_state;

    localparam logic [rdsrt_pkg::ROW_W-1:0] LAST_ROW = rdsrt_pkg::ROW_W'(rdsrt_pkg::ROWS - 1);

    t_state                           r_state, n_state;
    rdsrt_pkg::t_cmd                  r_cmd, n_cmd;
    logic                             r_mis, n_mis;
    logic [rdsrt_pkg::SEGMENTS-1:0]   r_mask, n_mask;
    logic                             r_verify, n_verify;
    logic [rdsrt_pkg::ROWS-1:0]       r_valid, n_valid;
    logic [rdsrt_pkg::ROW_W-1:0]      r_row, n_row;
    logic [rdsrt_pkg::ROW_W-1:0]      r_rd_row, n_rd_row;
    rdsrt_pkg::t_status               r_status, n_status;

    logic                             ram_we, ram_re;
    logic [rdsrt_pkg::ROW_W-1:0]      ram_waddr, ram_raddr;
    logic [15:0]                      ram_wdata, ram_rdata;
    logic [15:0]                      stored;
    logic [rdsrt_pkg::ROW_W-1:0]      row1;
    logic [rdsrt_pkg::SEGMENTS-1:0]   seg_bit, mask_next;

    logic                             res_push, res_full;
    rdsrt_pkg::t_result               res_data;
    logic [$bits(rdsrt_pkg::t_result)-1:0] res_q;

    rdsrt_ram #(
        .WIDTH(16),
        .DEPTH(rdsrt_pkg::ROWS)
    ) u_text_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // A row never written since the last clear reads as two spaces.
    assign stored    = r_valid[r_rd_row] ? ram_rdata : rdsrt_pkg::SPACE_PAIR;
    assign row1      = r_cmd.row0 + rdsrt_pkg::ROW_W'(1);
    assign seg_bit   = rdsrt_pkg::SEGMENTS'(1) << r_cmd.seg;
    assign mask_next = r_mask | seg_bit;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_mis     = r_mis;
        n_mask    = r_mask;
        n_verify  = r_verify;
        n_valid   = r_valid;
        n_row     = r_row;
        n_rd_row  = r_rd_row;
        n_status  = r_status;
        o_cmd_pop = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_cmd.row0;
        ram_wdata = r_cmd.word0;
        ram_re    = 1'b0;
        ram_raddr = r_cmd.row0;
        res_push  = 1'b0;
        res_data  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_mis     = 1'b0;
                    if (!i_cmd.is_text) begin
                        n_status = rdsrt_pkg::ST_IGNORED;
                        n_state  = S_EMIT;
                    end else if (r_verify) begin
                        n_state = S_RD0;
                    end else begin
                        n_state = S_WR0;
                    end
                end
            end
            S_RD0: begin
                ram_re   = 1'b1;
                n_rd_row = r_cmd.row0;
                n_state  = S_RD1;
            end
            S_RD1: begin
                n_mis = (stored != r_cmd.word0);
                if (r_cmd.two_rows) begin
                    ram_re    = 1'b1;
                    ram_raddr = row1;
                    n_rd_row  = row1;
                    n_state   = S_CHK;
                end else begin
                    n_state = S_DEC;
                end
            end
            S_CHK: begin
                n_mis   = r_mis || (stored != r_cmd.word1);
                n_state = S_DEC;
            end
            S_DEC: begin
                if (r_mis) begin
                    n_valid  = '0;
                    n_mask   = '0;
                    n_verify = 1'b0;
                    n_status = rdsrt_pkg::ST_MISMATCH;
                    n_state  = S_EMIT;
                end else begin
                    n_state = S_WR0;
                end
            end
            S_WR0: begin
                ram_we              = 1'b1;
                n_valid[r_cmd.row0] = 1'b1;
                n_state             = r_cmd.two_rows ? S_WR1 : S_UPD;
            end
            S_WR1: begin
                ram_we         = 1'b1;
                ram_waddr      = row1;
                ram_wdata      = r_cmd.word1;
                n_valid[row1]  = 1'b1;
                n_state        = S_UPD;
            end
            S_UPD: begin
                if (mask_next != rdsrt_pkg::ALL_SEGMENTS) begin
                    n_mask   = mask_next;
                    n_status = rdsrt_pkg::ST_STORED;
                    n_state  = S_EMIT;
                end else begin
                    n_mask = '0;
                    if (!r_verify) begin
                        n_verify = 1'b1;
                        n_status = rdsrt_pkg::ST_FIRST_DONE;
                        n_state  = S_EMIT;
                    end else begin
                        n_verify = 1'b0;
                        n_row    = '0;
                        n_state  = S_SRD;
                    end
                end
            end
            S_EMIT: begin
                if (!res_full) begin
                    res_push        = 1'b1;
                    res_data.status = r_status;
                    res_data.last   = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_SRD: begin
                ram_re    = 1'b1;
                ram_raddr = r_row;
                n_rd_row  = r_row;
                n_state   = S_SHI;
            end
            S_SHI: begin
                if (!res_full) begin
                    res_push               = 1'b1;
                    res_data.status        = rdsrt_pkg::ST_TEXT;
                    res_data.text_char     = stored[15:8];
                    res_data.char_position = {r_row, 1'b0};
                    n_state                = S_SLO;
                end
            end
            S_SLO: begin
                if (!res_full) begin
                    res_push               = 1'b1;
                    res_data.status        = rdsrt_pkg::ST_TEXT;
                    res_data.text_char     = stored[7:0];
                    res_data.char_position = {r_row, 1'b1};
                    res_data.last          = (r_row == LAST_ROW);
                    if (r_row == LAST_ROW) begin
                        n_state = S_IDLE;
                    end else begin
                        n_row   = r_row + rdsrt_pkg::ROW_W'(1);
                        n_state = S_SRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mask   <= '0;
            r_verify <= 1'b0;
            r_valid  <= '0;
        end else begin
            r_state  <= n_state;
            r_mask   <= n_mask;
            r_verify <= n_verify;
            r_valid  <= n_valid;
        end
        r_cmd    <= n_cmd;
        r_mis    <= n_mis;
        r_row    <= n_row;
        r_rd_row <= n_rd_row;
        r_status <= n_status;
    end

    rdsrt_queue #(
        .WIDTH($bits(rdsrt_pkg::t_result))
    ) u_res_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (res_data),
        .o_full (res_full),
        .i_pop  (i_res_pop),
        .o_data (res_q),
        .o_empty(o_res_empty)
    );

    assign o_res = rdsrt_pkg::t_result'(res_q);

`ifndef ASSERT_OFF
    // A mismatch can only be found while verification is armed.
    a_mis_in_verify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC && r_mis) |-> r_verify)
        else $error("mismatch flagged outside the verification pass");

    // A mismatch leaves an empty store and an empty segment mask.
    a_mis_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC && r_mis) |=> (r_valid == '0 && r_mask == '0 && !r_verify))
        else $error("mismatch did not clear the text state");

    // Streaming starts only when the second pass has seen every segment.
    a_stream_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && n_state == S_SRD)
            |-> (r_verify && mask_next == rdsrt_pkg::ALL_SEGMENTS))
        else $error("text streamed before the second pass completed");

    // Text characters come out of the streaming states only.
    a_text_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_push && res_data.status == rdsrt_pkg::ST_TEXT)
            |-> (r_state == S_SHI || r_state == S_SLO))
        else $error("text result pushed outside streaming");
`endif

endmodule

[rtl/rds_radiotext_assembler.sv]
// ----------------------------------------------------------------------------
// rds_radiotext_assembler - RDS RadioText (groups 2A/2B) assembler
// Collects RadioText characters from received groups, confirms the message
// over a second full pass and streams the finished 64-character text.
// ----------------------------------------------------------------------------
// Push one received group (blocks B, C, D) per transaction; each group gives
// exactly one result transaction (ignored, stored, first pass complete or
// mismatch cleared), except the group that completes the confirming pass,
// which gives 64 text transactions, character 0 first, with last set on the
// final one. Groups whose type is not 2 pass through as "ignored". Version A
// groups carry four characters, version B two; both share one segment mask.
// Once all 16 segments are seen, the next pass compares every character
// with the stored text before writing it; any difference clears the text to
// spaces and restarts collection. Sequencing: the sequencer handles one group
// at a time; the compare reads of a confirming group go through the single
// read port of the text RAM, which reads one character pair per cycle.
// Streaming the text is paced by one RAM read and two result transactions
// per character pair, and stalls while the result queue is full. A two-entry
// queue on each side lets groups be taken and results be held while the
// sequencer runs, and no clearing pass is needed after reset: per-row valid
// bits return spaces for unwritten rows.
// ----------------------------------------------------------------------------
module rds_radiotext_assembler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // group input queue
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_block_b,
    input  logic [15:0] i_block_c,
    input  logic [15:0] i_block_d,
    // result output queue
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [7:0]  o_text_char,
    output logic [5:0]  o_char_position,
    output logic        o_last
);

    logic               cmd_valid;
    logic               cmd_pop;
    rdsrt_pkg::t_cmd    cmd;
    rdsrt_pkg::t_result res;

    // Front end: decode and hold groups until the sequencer takes them.
    rdsrt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_block_b  (i_block_b),
        .i_block_c  (i_block_c),
        .i_block_d  (i_block_d),
        .o_cmd_valid(cmd_valid),
        .o_cmd      (cmd),
        .i_cmd_pop  (cmd_pop)
    );

    // Back end: verify, store, track segments and stream the text.
    rdsrt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd),
        .o_cmd_pop  (cmd_pop),
        .i_res_pop  (pop),
        .o_res_empty(empty),
        .o_res      (res)
    );

    // Unpack the oldest waiting result onto the output ports.
    assign o_status        = res.status;
    assign o_text_char     = res.text_char;
    assign o_char_position = res.char_position;
    assign o_last          = res.last;

endmodule
